// File: sv/scmt_pkg.sv
package scmt_pkg;

  localparam int COORD_W = 16;
  localparam int MM_W    = 9;

  localparam logic signed [COORD_W-1:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] POS_MIN = 16'sh8000;
  localparam logic [MM_W-1:0] MIN_MOTION_RESET  = 9'd64;

  typedef enum logic [2:0] {
    VC_PASS    = 3'd0,
    VC_EMPTY   = 3'd1,
    VC_LEFT    = 3'd2,
    VC_RIGHT   = 3'd3,
    VC_MARGIN1 = 3'd4,
    VC_MARGIN2 = 3'd5
  } verdict_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] strip_x;
    logic signed [COORD_W-1:0] strip_y;
    logic                      in_diff_one;
    logic                      in_diff_two;
    logic signed [COORD_W-1:0] cluster_left_x;
    logic signed [COORD_W-1:0] cluster_right_x;
    logic                      last_strip;
  } strip_in_t;

  typedef struct packed {
    logic                      is_object;
    logic [2:0]                verdict_code;
    logic signed [COORD_W-1:0] first_min_x;
    logic signed [COORD_W-1:0] first_min_y;
    logic signed [COORD_W-1:0] first_max_x;
    logic signed [COORD_W-1:0] first_max_y;
    logic signed [COORD_W-1:0] second_min_x;
    logic signed [COORD_W-1:0] second_min_y;
    logic signed [COORD_W-1:0] second_max_x;
    logic signed [COORD_W-1:0] second_max_y;
  } verdict_out_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
  } box_t;

  localparam box_t BOX_EMPTY = '{valid: 1'b0, min_x: POS_MAX, min_y: POS_MAX,
                                 max_x: POS_MIN, max_y: POS_MIN};

endpackage

// File: sv/scmt_box.sv
module scmt_box (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,    // stage item consumed
  input  logic                              add,     // strip belongs to this box
  input  logic                              clear,   // last strip of cluster
  input  logic signed [scmt_pkg::COORD_W-1:0] x,
  input  logic signed [scmt_pkg::COORD_W-1:0] y,
  output scmt_pkg::box_t                    box_cur  // box including this strip
);
  import scmt_pkg::*;

  box_t box_r;
  box_t box_nxt;
  box_t merged;

  always_comb begin
    merged       = box_r;
    merged.valid = 1'b1;
    if (x < box_r.min_x) merged.min_x = x;
    if (y < box_r.min_y) merged.min_y = y;
    if (x > box_r.max_x) merged.max_x = x;
    if (y > box_r.max_y) merged.max_y = y;
  end

  assign box_cur = add ? merged : box_r;

  always_comb begin
    box_nxt = box_r;
    if (step) begin
      box_nxt = clear ? BOX_EMPTY : box_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= BOX_EMPTY;
    end else begin
      box_r <= box_nxt;
    end
  end

endmodule

// File: sv/scmt_judge.sv
module scmt_judge (
  input  scmt_pkg::box_t                      box_one,
  input  scmt_pkg::box_t                      box_two,
  input  logic signed [scmt_pkg::COORD_W-1:0] left_x,
  input  logic signed [scmt_pkg::COORD_W-1:0] right_x,
  input  logic [scmt_pkg::MM_W-1:0]           min_motion,
  output scmt_pkg::verdict_t                  code,
  output scmt_pkg::box_t                      box_a,
  output scmt_pkg::box_t                      box_b
);
  import scmt_pkg::*;

  localparam int SPAN_W = COORD_W + 1;
  localparam int PROD_W = SPAN_W + MM_W + 1;
  localparam int MRG_W  = PROD_W - 8;

  logic                     both_valid;
  logic                     swap;
  logic signed [SPAN_W-1:0] span;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [MRG_W-1:0]  margin;
  logic signed [SPAN_W-1:0] gap_one;
  logic signed [SPAN_W-1:0] gap_two;
  logic signed [MRG_W-1:0]  gap_one_x;
  logic signed [MRG_W-1:0]  gap_two_x;

  assign both_valid = box_one.valid && box_two.valid;
  assign swap       = both_valid && (box_one.min_x != left_x);
  assign box_a      = swap ? box_two : box_one;
  assign box_b      = swap ? box_one : box_two;

  // margin = min_motion * span / 256, truncated toward zero
  assign span     = SPAN_W'(right_x) - SPAN_W'(left_x);
  assign prod     = $signed({1'b0, min_motion}) * span;
  assign prod_rnd = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
  assign margin   = prod_rnd[PROD_W-1:8];

  assign gap_one   = SPAN_W'(right_x) - SPAN_W'(box_a.max_x);
  assign gap_two   = SPAN_W'(box_b.min_x) - SPAN_W'(left_x);
  assign gap_one_x = MRG_W'(gap_one);
  assign gap_two_x = MRG_W'(gap_two);

  always_comb begin
    if (!both_valid) begin
      code = VC_EMPTY;
    end else if (box_a.min_x != left_x) begin
      code = VC_LEFT;
    end else if (box_b.max_x != right_x) begin
      code = VC_RIGHT;
    end else if (gap_one_x < margin) begin
      code = VC_MARGIN1;
    end else if (gap_two_x < margin) begin
      code = VC_MARGIN2;
    end else begin
      code = VC_PASS;
    end
  end

endmodule

// File: sv/strip_cluster_motion_test.sv
// Channel | Ports                          | Moves
// --------+--------------------------------+--------------------------------------
// input   | in_valid, in_stall, in_data    | one strip item per handshake
// output  | out_valid, out_stall, out_data | one verdict item per cluster
// config  | cfg_we, cfg_wdata              | min_motion write, no read-back
//
// One strip item per cycle sustained while in_stall is low. An accepted
// strip passes the input register, then box update and judge logic into
// the output register. Reset (rst_n, synchronous) empties both boxes and sets
// min_motion to 64. in_stall rises only while a last-strip item waits in the
// input register and the output register holds an untaken verdict.
module strip_cluster_motion_test (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  scmt_pkg::strip_in_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output scmt_pkg::verdict_out_t      out_data,
  input  logic                        cfg_we,
  input  logic [scmt_pkg::MM_W-1:0]   cfg_wdata
);
  import scmt_pkg::*;

  // configuration
  logic [MM_W-1:0] min_motion_r;

  // input register
  logic      s1_valid_r;
  strip_in_t s1_r;
  logic      s1_block;
  logic      s1_go;

  // output register
  logic         out_valid_r;
  verdict_out_t out_r;
  verdict_out_t out_nxt;

  box_t     box_one_cur;
  box_t     box_two_cur;
  box_t     box_a;
  box_t     box_b;
  verdict_t code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_motion_r <= MIN_MOTION_RESET;
    end else if (cfg_we) begin
      min_motion_r <= cfg_wdata;
    end
  end

  // Only a last strip needs the output register; plain strips always drain.
  assign s1_block = s1_valid_r && s1_r.last_strip && out_valid_r && out_stall;
  assign s1_go    = s1_valid_r && !s1_block;
  assign in_stall = s1_block;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
  end

  // One accumulator per difference image; the last strip is merged
  // before judging, then the box returns to empty.
  scmt_box u_box_one (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .add     (s1_r.in_diff_one),
    .clear   (s1_r.last_strip),
    .x       (s1_r.strip_x),
    .y       (s1_r.strip_y),
    .box_cur (box_one_cur)
  );

  scmt_box u_box_two (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .add     (s1_r.in_diff_two),
    .clear   (s1_r.last_strip),
    .x       (s1_r.strip_x),
    .y       (s1_r.strip_y),
    .box_cur (box_two_cur)
  );

  scmt_judge u_judge (
    .box_one    (box_one_cur),
    .box_two    (box_two_cur),
    .left_x     (s1_r.cluster_left_x),
    .right_x    (s1_r.cluster_right_x),
    .min_motion (min_motion_r),
    .code       (code),
    .box_a      (box_a),
    .box_b      (box_b)
  );

  always_comb begin
    out_nxt.is_object    = (code == VC_PASS);
    out_nxt.verdict_code = code;
    out_nxt.first_min_x  = box_a.min_x;
    out_nxt.first_min_y  = box_a.min_y;
    out_nxt.first_max_x  = box_a.max_x;
    out_nxt.first_max_y  = box_a.max_y;
    out_nxt.second_min_x = box_b.min_x;
    out_nxt.second_min_y = box_b.min_y;
    out_nxt.second_max_x = box_b.max_x;
    out_nxt.second_max_y = box_b.max_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_r.last_strip) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_r.last_strip) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_is_object_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_object == (out_data.verdict_code == VC_PASS)))
    else $error("is_object disagrees with verdict_code");

  a_last_strip_loads_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_r.last_strip) |=> out_valid)
    else $error("last strip consumed without a verdict");

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_r.last_strip && out_valid && out_stall))
    else $error("input stalled without a pending last strip");

  a_code_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.verdict_code != 3'd6 && out_data.verdict_code != 3'd7))
    else $error("verdict_code out of range");
`endif

endmodule
